// ===== sv/kvt_pkg.sv =====
`default_nettype none

package kvt_pkg;

   typedef enum logic [1:0] {
      MODE_PUT    = 2'd0,
      MODE_GET    = 2'd1,
      MODE_DELETE = 2'd2,
      MODE_CLEAR  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_EMPTY     = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_SHIFT,
      S_HOLD
   } state_type;

   // finished item waiting for the output register
   typedef struct packed {
      logic       valid;
      status_type status;
   } result_type;

endpackage

`default_nettype wire

// ===== sv/kvt_ram.sv =====
`default_nettype none

module kvt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_BITS = $clog2(DEPTH)
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]     wr_data,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic      [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sv/kvt_seq.sv =====
`default_nettype none

module kvt_seq import kvt_pkg::*; #(
   parameter int TABLE_DEPTH = 16,
   parameter int KEY_BITS    = 32,
   parameter int VALUE_BITS  = 32,
   localparam int IDX_BITS   = $clog2(TABLE_DEPTH),
   localparam int CNT_BITS   = $clog2(TABLE_DEPTH + 1),
   localparam int ENT_BITS   = KEY_BITS + VALUE_BITS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [1:0]            req_mode,
   input  wire logic [KEY_BITS-1:0]   req_key,
   input  wire logic [VALUE_BITS-1:0] req_value,
   output logic                       mem_wr_en,
   output logic      [IDX_BITS-1:0]   mem_wr_addr,
   output logic      [ENT_BITS-1:0]   mem_wr_data,
   output logic      [IDX_BITS-1:0]   mem_rd_addr,
   input  wire logic [ENT_BITS-1:0]   mem_rd_data,
   output result_type                 res,
   output logic      [VALUE_BITS-1:0] res_value,
   input  wire logic                  res_take,
   output logic      [CNT_BITS-1:0]   fill_count
);

   state_type             state_ff, state_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic [CNT_BITS-1:0]   issue_ff, issue_in;
   logic [CNT_BITS-1:0]   cmp_ff, cmp_in;
   logic                  is_del_ff, is_del_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   status_type            status_ff, status_in;
   logic [VALUE_BITS-1:0] value_ff, value_in;

   mode_type              mode;
   logic                  accept;
   logic                  full;
   logic                  empty;
   logic                  hit;
   logic                  last_cmp;
   logic                  shift_last;
   logic [KEY_BITS-1:0]   rd_key;
   logic [VALUE_BITS-1:0] rd_val;

   assign mode       = mode_type'(req_mode);
   assign req_ready  = (state_ff == S_IDLE);
   assign accept     = req_valid && req_ready;
   assign full       = (count_ff == CNT_BITS'(TABLE_DEPTH));
   assign empty      = (count_ff == '0);
   assign rd_key     = mem_rd_data[ENT_BITS-1:VALUE_BITS];
   assign rd_val     = mem_rd_data[VALUE_BITS-1:0];
   assign hit        = (rd_key == key_ff);
   assign last_cmp   = (CNT_BITS'(cmp_ff + CNT_BITS'(1)) == count_ff);
   // the entry just written was the second to last one
   assign shift_last = (CNT_BITS'(cmp_ff + CNT_BITS'(2)) == count_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if ((mode inside {MODE_GET, MODE_DELETE}) && !empty) begin
                  state_in = S_SCAN;
               end else begin
                  state_in = S_HOLD;
               end
            end
         end
         S_SCAN: begin
            if (hit) begin
               state_in = (is_del_ff && !last_cmp) ? S_SHIFT : S_HOLD;
            end else if (last_cmp) begin
               state_in = S_HOLD;
            end
         end
         S_SHIFT: begin
            if (shift_last) begin
               state_in = S_HOLD;
            end
         end
         S_HOLD: begin
            if (res_take) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      count_in    = count_ff;
      issue_in    = issue_ff;
      cmp_in      = cmp_ff;
      is_del_in   = is_del_ff;
      key_in      = key_ff;
      status_in   = status_ff;
      value_in    = value_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = cmp_ff[IDX_BITS-1:0];
      mem_wr_data = mem_rd_data;
      mem_rd_addr = '0;
      case (state_ff)
         S_IDLE: begin
            mem_wr_addr = count_ff[IDX_BITS-1:0];
            mem_wr_data = {req_key, req_value};
            if (accept) begin
               key_in    = req_key;
               is_del_in = (mode == MODE_DELETE);
               value_in  = '0;
               status_in = ST_OK;
               // entry 0 is read during the accept cycle
               issue_in  = CNT_BITS'(1);
               cmp_in    = '0;
               case (mode)
                  MODE_PUT: begin
                     if (full) begin
                        status_in = ST_FULL;
                     end else begin
                        mem_wr_en = 1'b1;
                        count_in  = CNT_BITS'(count_ff + CNT_BITS'(1));
                     end
                  end
                  MODE_GET, MODE_DELETE: begin
                     if (empty) begin
                        status_in = ST_EMPTY;
                     end
                  end
                  MODE_CLEAR: count_in = '0;
                  default: status_in = ST_OK;
               endcase
            end
         end
         S_SCAN: begin
            mem_rd_addr = (issue_ff < CNT_BITS'(TABLE_DEPTH)) ? issue_ff[IDX_BITS-1:0] : '0;
            issue_in    = CNT_BITS'(issue_ff + CNT_BITS'(1));
            if (hit) begin
               value_in = rd_val;
               // cmp stays put: it becomes the first slot to overwrite
               if (is_del_ff && last_cmp) begin
                  count_in = CNT_BITS'(count_ff - CNT_BITS'(1));
               end
            end else begin
               cmp_in = CNT_BITS'(cmp_ff + CNT_BITS'(1));
               if (last_cmp) begin
                  status_in = ST_NOT_FOUND;
               end
            end
         end
         S_SHIFT: begin
            mem_rd_addr = (issue_ff < CNT_BITS'(TABLE_DEPTH)) ? issue_ff[IDX_BITS-1:0] : '0;
            mem_wr_en   = 1'b1;
            issue_in    = CNT_BITS'(issue_ff + CNT_BITS'(1));
            cmp_in      = CNT_BITS'(cmp_ff + CNT_BITS'(1));
            if (shift_last) begin
               count_in = CNT_BITS'(count_ff - CNT_BITS'(1));
            end
         end
         S_HOLD: begin
            mem_rd_addr = '0;
         end
         default: mem_rd_addr = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      issue_ff  <= issue_in;
      cmp_ff    <= cmp_in;
      is_del_ff <= is_del_in;
      key_ff    <= key_in;
      status_ff <= status_in;
      value_ff  <= value_in;
   end

   assign res.valid  = (state_ff == S_HOLD);
   assign res.status = status_ff;
   assign res_value  = value_ff;
   assign fill_count = count_ff;

`ifndef SYNTHESIS
   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(TABLE_DEPTH))
      else $error("entry count above table depth");

   a_shift_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT) |-> (mem_wr_addr != mem_rd_addr))
      else $error("shift writes the entry it reads");

   a_scan_within_fill: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN || state_ff == S_SHIFT) |-> (cmp_ff < count_ff))
      else $error("compare index beyond filled entries");

   a_put_grows: assert property (@(posedge clock) disable iff (reset)
      (accept && mode == MODE_PUT && !full) |=>
         (count_ff == CNT_BITS'($past(count_ff) + CNT_BITS'(1))))
      else $error("put did not add an entry");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (accept && mode == MODE_CLEAR) |=> (count_ff == '0 && state_ff == S_HOLD))
      else $error("clear did not empty the table");
`endif

endmodule

`default_nettype wire

// ===== sv/linear_key_value_table.sv =====
// linear key/value table: entries are kept packed in insertion order in one
// synchronous ram of TABLE_DEPTH words, each word a key and its value.
// req channel (valid/ready): mode, key, value. put appends, get returns the
// value of the oldest matching key, delete removes it and moves later
// entries down one slot, clear empties the table.
// rsp channel (valid/ready): status, found_value, entry_count; one rsp item
// for every req item, in order.
// one req item is worked on at a time. put, clear and requests refused as
// empty or full go straight from acceptance to the result stage. get and
// delete read the ram one entry a cycle until a match or the last entry;
// delete then moves each later entry down one slot. the next req item is
// taken in the cycle after the result leaves the internal result stage.
// rsp has its own output register: a stalled rsp item does not stop the next
// req item from being accepted and worked on; it waits only at the end.
// reset empties the table and drops any pending item; ram contents are not
// cleared, since slots at or above the entry count are never used.
`default_nettype none

module linear_key_value_table import kvt_pkg::*; #(
   parameter int TABLE_DEPTH = 16,
   parameter int KEY_BITS    = 32,
   parameter int VALUE_BITS  = 32,
   localparam int CNT_BITS   = $clog2(TABLE_DEPTH + 1)
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [1:0]            req_mode,
   input  wire logic [KEY_BITS-1:0]   req_key,
   input  wire logic [VALUE_BITS-1:0] req_value,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic      [1:0]            rsp_status,
   output logic      [VALUE_BITS-1:0] rsp_found_value,
   output logic      [CNT_BITS-1:0]   rsp_entry_count
);

   localparam int IDX_BITS = $clog2(TABLE_DEPTH);
   localparam int ENT_BITS = KEY_BITS + VALUE_BITS;

   logic                  mem_wr_en;
   logic [IDX_BITS-1:0]   mem_wr_addr;
   logic [ENT_BITS-1:0]   mem_wr_data;
   logic [IDX_BITS-1:0]   mem_rd_addr;
   logic [ENT_BITS-1:0]   mem_rd_data;
   result_type            res;
   logic [VALUE_BITS-1:0] res_value;
   logic [CNT_BITS-1:0]   fill_count;
   logic                  take;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [1:0]            rsp_status_ff;
   logic [VALUE_BITS-1:0] rsp_value_ff;
   logic [CNT_BITS-1:0]   rsp_count_ff;

   kvt_ram #(
      .WIDTH (ENT_BITS),
      .DEPTH (TABLE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   kvt_seq #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .KEY_BITS    (KEY_BITS),
      .VALUE_BITS  (VALUE_BITS)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_mode    (req_mode),
      .req_key     (req_key),
      .req_value   (req_value),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .res         (res),
      .res_value   (res_value),
      .res_take    (take),
      .fill_count  (fill_count)
   );

   // output register is free when empty or being emptied this cycle
   assign take = res.valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (take) begin
         rsp_status_ff <= res.status;
         rsp_value_ff  <= res_value;
         rsp_count_ff  <= fill_count;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found_value = rsp_value_ff;
   assign rsp_entry_count = rsp_count_ff;

endmodule

`default_nettype wire
